>>> hdl/ccr_pkg.sv
// ccr_pkg: constants, stage record types and per-stage step functions
// for the circle pair collision pipeline. No dependencies.
package ccr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NORM_FRAC  = 26;                 // normal is Q1.26
    localparam int SQ_STEPS   = 32;                 // root bits of a 64-bit square
    localparam int NDIV_STEPS = NORM_FRAC + 1;      // normal quotient bits
    localparam int MDIV_STEPS = 35;                 // mass-share quotient bits
    localparam int LANES      = 4;                  // sa, sb, ja, jb

    // squared distance below 0.00001 in real units counts as coincident
    localparam logic [64:0] EPS_LIM =
        ((65'd1 << (2 * FRAC_BITS)) + 65'd99999) / 65'd100000;

    localparam logic [1:0] OUT_IMPULSE    = 2'd0;
    localparam logic [1:0] OUT_SEPARATE   = 2'd1;
    localparam logic [1:0] OUT_NO_CONTACT = 2'd2;
    localparam logic [1:0] OUT_IMMOVABLE  = 2'd3;

    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
    typedef logic [7:0][31:0] t_bodies;

    typedef struct packed {
        t_bodies     bod;
        logic [23:0] ia;
        logic [23:0] ib;
        logic [24:0] tot;
        logic [8:0]  e;
        logic [31:0] rs;
        logic [31:0] mx;
        logic [31:0] my;
        logic        sx;
        logic        sy;
        logic        contact;
        logic        eps;
    } t_ctx;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] x;
    } t_sq;

    typedef struct packed {
        logic [31:0]           rem;
        logic [NDIV_STEPS-1:0] q;
        logic [NDIV_STEPS-1:0] n;
    } t_nd;

    typedef struct packed {
        logic [24:0]           rem;
        logic [MDIV_STEPS-1:0] q;
        logic [MDIV_STEPS-1:0] n;
    } t_md;

    typedef struct packed {
        t_bodies     bod;
        logic [24:0] tot;
        logic [1:0]  code;
        logic [26:0] nxm;
        logic [26:0] nym;
        logic        nxs;
        logic        nys;
    } t_mid;

    // one digit of the restoring square root
    function automatic t_sq sq_step(t_sq s);
        logic [35:0] acc;
        logic [35:0] trial;
        logic        ge;
        t_sq         r;
        acc    = {s.rem, s.x[63:62]};
        trial  = {2'b00, s.root, 2'b01};
        ge     = (acc >= trial);
        r.rem  = ge ? 34'(acc - trial) : acc[33:0];
        r.root = {s.root[30:0], ge};
        r.x    = {s.x[61:0], 2'b00};
        return r;
    endfunction

    // one quotient bit of the normal divide
    function automatic t_nd nd_step(t_nd s, logic [31:0] d);
        logic [32:0] acc;
        logic        ge;
        t_nd         r;
        acc   = {s.rem, s.n[NDIV_STEPS-1]};
        ge    = (acc >= {1'b0, d});
        r.rem = ge ? 32'(acc - {1'b0, d}) : acc[31:0];
        r.q   = {s.q[NDIV_STEPS-2:0], ge};
        r.n   = {s.n[NDIV_STEPS-2:0], 1'b0};
        return r;
    endfunction

    // one quotient bit of the inverse-mass share divide
    function automatic t_md md_step(t_md s, logic [24:0] d);
        logic [25:0] acc;
        logic        ge;
        t_md         r;
        acc   = {s.rem, s.n[MDIV_STEPS-1]};
        ge    = (acc >= {1'b0, d});
        r.rem = ge ? 25'(acc - {1'b0, d}) : acc[24:0];
        r.q   = {s.q[MDIV_STEPS-2:0], ge};
        r.n   = {s.n[MDIV_STEPS-2:0], 1'b0};
        return r;
    endfunction

endpackage

>>> hdl/circle_collision_resolve.sv
// circle_collision_resolve: fully pipelined collision response for a pair
// of circular bodies (contact test, normal, position split, impulse).
// Depends on ccr_pkg.
//
// Usage:
//  - Input channel (i_s_*): one request per accepted beat carries both bodies
//    (positions, velocities, radii, inverse mass and restitution).
//  - Output channel (o_m_*): one result per request, in order; tdata holds the
//    eight corrected values, tuser the outcome code.
//  - Throughput: one request per clock while the output is not stalled. The
//    32-step square root and the 27-step and 35-step dividers each retire one
//    bit per pipeline stage.
//  - Reset (i_rst_n low, synchronous) clears every valid bit; o_s_tready is
//    low during reset and for one cycle after it.
//  - Output stall: an output register plus a one-entry skid buffer follow the
//    pipeline. While the receiver holds off, one more result drops into the
//    skid; only then does the whole pipeline freeze and o_s_tready go low.
//    Nothing is lost or repeated.
//  - Outcome: 0 impulse applied, 1 separating (positions only), 2 no contact,
//    3 both immovable. No contact and both immovable return the inputs
//    unchanged.
module circle_collision_resolve (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_props,
    // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_props
    input  logic [383:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
    // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y
    output logic [255:0] o_m_tdata,
    // outcome
    output logic [1:0]   o_m_tuser
);

    localparam int SQ   = ccr_pkg::SQ_STEPS;
    localparam int ND   = ccr_pkg::NDIV_STEPS;
    localparam int MD   = ccr_pkg::MDIV_STEPS;
    localparam int NF   = ccr_pkg::NORM_FRAC;
    localparam int NUMW = 32 + ND;      // normal dividend width

    logic w_ce;                          // pipeline advance
    logic r_run;

    // ---------------- stage registers ----------------
    logic              r1_v;
    ccr_pkg::t_ctx     r1_ctx, n1_ctx;

    logic              r2_v;
    ccr_pkg::t_ctx     r2_ctx;
    logic [63:0]       r2_sqx, r2_sqy, r2_rs2;

    // square root pipe; entry 0 is the contact-test stage
    logic              r_sq_v   [0:SQ];
    ccr_pkg::t_sq      r_sq     [0:SQ];
    ccr_pkg::t_ctx     r_sq_ctx [0:SQ];

    // normal divide pipe, x and y in parallel
    logic              r_nd_v    [0:ND];
    ccr_pkg::t_nd      r_ndx     [0:ND];
    ccr_pkg::t_nd      r_ndy     [0:ND];
    logic [31:0]       r_nd_dist [0:ND];
    ccr_pkg::t_ctx     r_nd_ctx  [0:ND];

    logic              r_p1_v;
    ccr_pkg::t_mid     r_p1;
    logic [31:0]       r_p1_pen;
    logic [23:0]       r_p1_ia, r_p1_ib;
    logic [8:0]        r_p1_e;

    logic              r_p2_v;
    ccr_pkg::t_mid     r_p2;
    logic [55:0]       r_p2_pia, r_p2_pib;
    logic signed [60:0] r_p2_wx, r_p2_wy;
    logic [23:0]       r_p2_ia, r_p2_ib;
    logic [8:0]        r_p2_e;

    logic              r_p3_v;
    ccr_pkg::t_mid     r_p3;
    logic [59:0]       r_p3_nsa, r_p3_nsb;
    logic [33:0]       r_p3_vn;
    logic [23:0]       r_p3_ia, r_p3_ib;
    logic [8:0]        r_p3_e;

    logic              r_p4_v;
    ccr_pkg::t_mid     r_p4;
    logic [MD-1:0]     r_p4_k;
    logic [59:0]       r_p4_nsa, r_p4_nsb;
    logic [23:0]       r_p4_ia, r_p4_ib;

    // share divide pipe, four lanes
    logic              r_md_v   [0:MD];
    ccr_pkg::t_md      r_md     [0:MD][0:ccr_pkg::LANES-1];
    ccr_pkg::t_mid     r_md_ctx [0:MD];

    logic              r_q1_v;
    ccr_pkg::t_mid     r_q1;
    logic [61:0]       r_q1_m [0:7];

    logic              r_q2_v;
    ccr_pkg::t_mid     r_q2;
    logic signed [36:0] r_q2_d [0:7];

    logic              r_f_v;
    ccr_pkg::t_bodies  r_f_bod, n_f_bod;
    logic [1:0]        r_f_code;

    logic              r_o_v, r_sk_v;
    ccr_pkg::t_bodies  r_o_bod, r_sk_bod;
    logic [1:0]        r_o_code, r_sk_code;

    // next values of the arithmetic stages
    logic [64:0]       n3_sum;
    ccr_pkg::t_ctx     n3_ctx;
    logic [NUMW-1:0]   n_numx, n_numy;
    ccr_pkg::t_mid     n_p1;
    logic [31:0]       n_p1_pen;
    logic signed [32:0] n_rvx, n_rvy;
    logic signed [27:0] n_nx, n_ny;
    logic signed [61:0] n_wide;
    logic [61:0]       n_negw;
    ccr_pkg::t_mid     n_p3;
    logic [43:0]       n_kprod;
    logic [59:0]       n_nja, n_njb;
    logic [61:0]       n_rnd [0:7];

    assign w_ce       = !r_sk_v;
    assign o_s_tready = r_run && !r_sk_v;

    // ---------------- unpack, differences ----------------
    always_comb begin
        logic signed [32:0] dx, dy;
        logic [8:0]         ea, eb;
        n1_ctx.bod[0] = i_s_tdata[31:0];
        n1_ctx.bod[1] = i_s_tdata[63:32];
        n1_ctx.bod[2] = i_s_tdata[95:64];
        n1_ctx.bod[3] = i_s_tdata[127:96];
        n1_ctx.bod[4] = i_s_tdata[223:192];
        n1_ctx.bod[5] = i_s_tdata[255:224];
        n1_ctx.bod[6] = i_s_tdata[287:256];
        n1_ctx.bod[7] = i_s_tdata[319:288];
        dx = 33'($signed(i_s_tdata[31:0]))  - 33'($signed(i_s_tdata[223:192]));
        dy = 33'($signed(i_s_tdata[63:32])) - 33'($signed(i_s_tdata[255:224]));
        n1_ctx.sx = dx[32];
        n1_ctx.sy = dy[32];
        n1_ctx.mx = dx[32] ? 32'(-dx) : dx[31:0];
        n1_ctx.my = dy[32] ? 32'(-dy) : dy[31:0];
        n1_ctx.rs = {1'b0, i_s_tdata[158:128]} + {1'b0, i_s_tdata[350:320]};
        n1_ctx.ia = i_s_tdata[182:159];
        n1_ctx.ib = i_s_tdata[374:351];
        ea = i_s_tdata[191:183];
        eb = i_s_tdata[383:375];
        n1_ctx.e   = (ea < eb) ? ea : eb;
        n1_ctx.tot = {1'b0, n1_ctx.ia} + {1'b0, n1_ctx.ib};
        n1_ctx.contact = 1'b0;
        n1_ctx.eps     = 1'b0;
    end

    // contact test on exact squares
    always_comb begin
        n3_sum         = {1'b0, r2_sqx} + {1'b0, r2_sqy};
        n3_ctx         = r2_ctx;
        n3_ctx.contact = (n3_sum <= {1'b0, r2_rs2});
        n3_ctx.eps     = (n3_sum < ccr_pkg::EPS_LIM);
    end

    // normal dividends: |d| * 2^26 + dist/2
    always_comb begin
        n_numx = {1'b0, r_sq_ctx[SQ].mx, {NF{1'b0}}} + NUMW'(r_sq[SQ].root >> 1);
        n_numy = {1'b0, r_sq_ctx[SQ].my, {NF{1'b0}}} + NUMW'(r_sq[SQ].root >> 1);
    end

    // normal select, outcome base, penetration
    always_comb begin
        n_p1.bod = r_nd_ctx[ND].bod;
        n_p1.tot = r_nd_ctx[ND].tot;
        if (!r_nd_ctx[ND].contact) begin
            n_p1.code = ccr_pkg::OUT_NO_CONTACT;
        end else if (r_nd_ctx[ND].tot == '0) begin
            n_p1.code = ccr_pkg::OUT_IMMOVABLE;
        end else begin
            n_p1.code = ccr_pkg::OUT_IMPULSE;
        end
        if (r_nd_ctx[ND].eps) begin
            // coincident centres: normal (1,0), full radius sum
            n_p1.nxm = 27'(1) << NF;
            n_p1.nxs = 1'b0;
            n_p1.nym = '0;
            n_p1.nys = 1'b0;
            n_p1_pen = r_nd_ctx[ND].rs;
        end else begin
            n_p1.nxm = r_ndx[ND].q;
            n_p1.nxs = r_nd_ctx[ND].sx;
            n_p1.nym = r_ndy[ND].q;
            n_p1.nys = r_nd_ctx[ND].sy;
            n_p1_pen = r_nd_ctx[ND].rs - r_nd_dist[ND];
        end
    end

    // relative velocity along the normal
    always_comb begin
        n_rvx = 33'($signed(r_p1.bod[2])) - 33'($signed(r_p1.bod[6]));
        n_rvy = 33'($signed(r_p1.bod[3])) - 33'($signed(r_p1.bod[7]));
        n_nx  = r_p1.nxs ? -$signed({1'b0, r_p1.nxm}) : $signed({1'b0, r_p1.nxm});
        n_ny  = r_p1.nys ? -$signed({1'b0, r_p1.nym}) : $signed({1'b0, r_p1.nym});
    end

    always_comb begin
        n_wide = 62'(r_p2_wx) + 62'(r_p2_wy);
        n_negw = 62'(-n_wide);
        n_p3   = r_p2;
        if (r_p2.code == ccr_pkg::OUT_IMPULSE && !n_wide[61] && n_wide != '0) begin
            n_p3.code = ccr_pkg::OUT_SEPARATE;
        end
    end

    // impulse scaled by (1 + e), e in Q1.8
    assign n_kprod = 44'(r_p3_vn) * 44'(10'd256 + 10'(r_p3_e));

    always_comb begin
        n_nja = 60'(r_p4_k) * 60'(r_p4_ia) + 60'(r_p4.tot >> 1);
        n_njb = 60'(r_p4_k) * 60'(r_p4_ib) + 60'(r_p4.tot >> 1);
    end

    // round half away from zero after the Q1.26 product
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_rnd[i] = r_q1_m[i] + (62'd1 << (NF - 1));
        end
    end

    // apply deltas, saturate, keep inputs where the outcome says so
    always_comb begin
        logic signed [37:0] sum;
        logic               upd;
        for (int i = 0; i < 8; i++) begin
            sum = 38'($signed(r_q2.bod[i])) + 38'(r_q2_d[i]);
            if (i % 4 < 2) begin
                upd = (r_q2.code == ccr_pkg::OUT_IMPULSE) ||
                      (r_q2.code == ccr_pkg::OUT_SEPARATE);
            end else begin
                upd = (r_q2.code == ccr_pkg::OUT_IMPULSE);
            end
            if (!upd) begin
                n_f_bod[i] = r_q2.bod[i];
            end else if (sum > 38'sd2147483647) begin
                n_f_bod[i] = 32'h7FFF_FFFF;
            end else if (sum < -38'sd2147483648) begin
                n_f_bod[i] = 32'h8000_0000;
            end else begin
                n_f_bod[i] = sum[31:0];
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            for (int k = 0; k <= SQ; k++) r_sq_v[k] <= 1'b0;
            for (int k = 0; k <= ND; k++) r_nd_v[k] <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            for (int k = 0; k <= MD; k++) r_md_v[k] <= 1'b0;
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
            r_f_v  <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (w_ce) begin
                r1_v      <= i_s_tvalid && o_s_tready;
                r2_v      <= r1_v;
                r_sq_v[0] <= r2_v;
                for (int k = 0; k < SQ; k++) r_sq_v[k+1] <= r_sq_v[k];
                r_nd_v[0] <= r_sq_v[SQ];
                for (int k = 0; k < ND; k++) r_nd_v[k+1] <= r_nd_v[k];
                r_p1_v    <= r_nd_v[ND];
                r_p2_v    <= r_p1_v;
                r_p3_v    <= r_p2_v;
                r_p4_v    <= r_p3_v;
                r_md_v[0] <= r_p4_v;
                for (int k = 0; k < MD; k++) r_md_v[k+1] <= r_md_v[k];
                r_q1_v    <= r_md_v[MD];
                r_q2_v    <= r_q1_v;
                r_f_v     <= r_q2_v;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_ctx <= n1_ctx;

            r2_ctx <= r1_ctx;
            r2_sqx <= 64'(r1_ctx.mx) * 64'(r1_ctx.mx);
            r2_sqy <= 64'(r1_ctx.my) * 64'(r1_ctx.my);
            r2_rs2 <= 64'(r1_ctx.rs) * 64'(r1_ctx.rs);

            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
            r_sq[0].x    <= n3_sum[63:0];
            r_sq_ctx[0]  <= n3_ctx;
            for (int k = 0; k < SQ; k++) begin
                r_sq[k+1]     <= ccr_pkg::sq_step(r_sq[k]);
                r_sq_ctx[k+1] <= r_sq_ctx[k];
            end

            r_ndx[0].rem <= n_numx[NUMW-1:ND];
            r_ndx[0].q   <= '0;
            r_ndx[0].n   <= n_numx[ND-1:0];
            r_ndy[0].rem <= n_numy[NUMW-1:ND];
            r_ndy[0].q   <= '0;
            r_ndy[0].n   <= n_numy[ND-1:0];
            r_nd_dist[0] <= r_sq[SQ].root;
            r_nd_ctx[0]  <= r_sq_ctx[SQ];
            for (int k = 0; k < ND; k++) begin
                r_ndx[k+1]     <= ccr_pkg::nd_step(r_ndx[k], r_nd_dist[k]);
                r_ndy[k+1]     <= ccr_pkg::nd_step(r_ndy[k], r_nd_dist[k]);
                r_nd_dist[k+1] <= r_nd_dist[k];
                r_nd_ctx[k+1]  <= r_nd_ctx[k];
            end

            r_p1     <= n_p1;
            r_p1_pen <= n_p1_pen;
            r_p1_ia  <= r_nd_ctx[ND].ia;
            r_p1_ib  <= r_nd_ctx[ND].ib;
            r_p1_e   <= r_nd_ctx[ND].e;

            r_p2     <= r_p1;
            r_p2_pia <= 56'(r_p1_pen) * 56'(r_p1_ia);
            r_p2_pib <= 56'(r_p1_pen) * 56'(r_p1_ib);
            r_p2_wx  <= 61'(n_rvx) * 61'(n_nx);
            r_p2_wy  <= 61'(n_rvy) * 61'(n_ny);
            r_p2_ia  <= r_p1_ia;
            r_p2_ib  <= r_p1_ib;
            r_p2_e   <= r_p1_e;

            r_p3     <= n_p3;
            r_p3_nsa <= 60'(r_p2_pia) + 60'(r_p2.tot >> 1);
            r_p3_nsb <= 60'(r_p2_pib) + 60'(r_p2.tot >> 1);
            r_p3_vn  <= n_negw[NF+33:NF] + 34'(n_negw[NF-1]);
            r_p3_ia  <= r_p2_ia;
            r_p3_ib  <= r_p2_ib;
            r_p3_e   <= r_p2_e;

            r_p4     <= r_p3;
            r_p4_k   <= 35'((n_kprod + 44'd128) >> 8);
            r_p4_nsa <= r_p3_nsa;
            r_p4_nsb <= r_p3_nsb;
            r_p4_ia  <= r_p3_ia;
            r_p4_ib  <= r_p3_ib;

            r_md[0][0].rem <= r_p4_nsa[59:MD];
            r_md[0][0].n   <= r_p4_nsa[MD-1:0];
            r_md[0][1].rem <= r_p4_nsb[59:MD];
            r_md[0][1].n   <= r_p4_nsb[MD-1:0];
            r_md[0][2].rem <= n_nja[59:MD];
            r_md[0][2].n   <= n_nja[MD-1:0];
            r_md[0][3].rem <= n_njb[59:MD];
            r_md[0][3].n   <= n_njb[MD-1:0];
            for (int l = 0; l < ccr_pkg::LANES; l++) r_md[0][l].q <= '0;
            r_md_ctx[0] <= r_p4;
            for (int k = 0; k < MD; k++) begin
                for (int l = 0; l < ccr_pkg::LANES; l++) begin
                    r_md[k+1][l] <= ccr_pkg::md_step(r_md[k][l], r_md_ctx[k].tot);
                end
                r_md_ctx[k+1] <= r_md_ctx[k];
            end

            // lanes: 0 sa, 1 sb, 2 ja, 3 jb
            r_q1 <= r_md_ctx[MD];
            r_q1_m[0] <= 62'(r_md[MD][0].q) * 62'(r_md_ctx[MD].nxm);
            r_q1_m[1] <= 62'(r_md[MD][0].q) * 62'(r_md_ctx[MD].nym);
            r_q1_m[2] <= 62'(r_md[MD][2].q) * 62'(r_md_ctx[MD].nxm);
            r_q1_m[3] <= 62'(r_md[MD][2].q) * 62'(r_md_ctx[MD].nym);
            r_q1_m[4] <= 62'(r_md[MD][1].q) * 62'(r_md_ctx[MD].nxm);
            r_q1_m[5] <= 62'(r_md[MD][1].q) * 62'(r_md_ctx[MD].nym);
            r_q1_m[6] <= 62'(r_md[MD][3].q) * 62'(r_md_ctx[MD].nxm);
            r_q1_m[7] <= 62'(r_md[MD][3].q) * 62'(r_md_ctx[MD].nym);

            // body B moves against the normal
            r_q2 <= r_q1;
            for (int i = 0; i < 8; i++) begin
                if (((i % 2 == 0) ? r_q1.nxs : r_q1.nys) ^ (i >= 4)) begin
                    r_q2_d[i] <= -$signed({1'b0, n_rnd[i][61:NF]});
                end else begin
                    r_q2_d[i] <= $signed({1'b0, n_rnd[i][61:NF]});
                end
            end

            r_f_bod  <= n_f_bod;
            r_f_code <= r_q2.code;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_m_tready) begin
                r_sk_v <= 1'b0;
            end
        end else if (!r_o_v || i_m_tready) begin
            r_o_v <= r_f_v;
        end else if (r_f_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (i_m_tready) begin
                r_o_bod  <= r_sk_bod;
                r_o_code <= r_sk_code;
            end
        end else if (!r_o_v || i_m_tready) begin
            r_o_bod  <= r_f_bod;
            r_o_code <= r_f_code;
        end else begin
            r_sk_bod  <= r_f_bod;
            r_sk_code <= r_f_code;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_bod;
    assign o_m_tuser  = r_o_code;

endmodule

>>> sim/ccr_checker.sv
// ccr_checker: watches both channels of circle_collision_resolve, predicts every
// result from the accepted request and compares it field by field.
// Depends on ccr_pkg.
`timescale 1ns / 1ps

module ccr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [383:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [255:0] i_m_tdata,
    input  logic [1:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    localparam longint NORM_ONE = longint'(1) << ccr_pkg::NORM_FRAC;

    typedef struct packed {
        logic [7:0][31:0] bod;
        logic [1:0]       outcome;
    } t_resolved;

    t_resolved resolved_q[$];
    int        fail_count = 0;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // v / d, rounded half away from zero
    function automatic longint round_div(longint v, longint unsigned d);
        longint unsigned q;
        q = (magnitude(v) + d / 2) / d;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint unsigned q;
        q = (magnitude(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_norm(longint v);
        if (v > NORM_ONE) return NORM_ONE;
        if (v < -NORM_ONE) return -NORM_ONE;
        return v;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_resolved resolve_pair(logic [383:0] d);
        longint apx, apy, avx, avy, bpx, bpy, bvx, bvy;
        longint dx, dy, nx, ny, sa, sb, wide, vn, k, ja, jb;
        longint unsigned ar, br, ia, ib, ea, eb, rs, mx, my, sq, d2, tot, pen, root_d, e;
        logic      contact;
        t_resolved r;
        apx = longint'($signed(d[31:0]));
        apy = longint'($signed(d[63:32]));
        avx = longint'($signed(d[95:64]));
        avy = longint'($signed(d[127:96]));
        ar  = d[158:128];
        ia  = d[182:159];
        ea  = d[191:183];
        bpx = longint'($signed(d[223:192]));
        bpy = longint'($signed(d[255:224]));
        bvx = longint'($signed(d[287:256]));
        bvy = longint'($signed(d[319:288]));
        br  = d[350:320];
        ib  = d[374:351];
        eb  = d[383:375];
        dx = apx - bpx;
        dy = apy - bpy;
        rs = ar + br;
        mx = magnitude(dx);
        my = magnitude(dy);
        contact = 1'b0;
        d2 = 0;
        // exact test; the squared sum may wrap, which means far apart
        if (mx <= rs && my <= rs) begin
            sq = mx * mx;
            d2 = sq + my * my;
            contact = (d2 >= sq) && (d2 <= rs * rs);
        end
        if (!contact) begin
            r.outcome = ccr_pkg::OUT_NO_CONTACT;
        end else if (ia + ib == 0) begin
            r.outcome = ccr_pkg::OUT_IMMOVABLE;
        end else begin
            tot = ia + ib;
            if (d2 < ccr_pkg::EPS_LIM) begin
                // coincident centers: fixed normal, full radius sum
                nx = NORM_ONE;
                ny = 0;
                pen = rs;
            end else begin
                root_d = floor_sqrt(d2);
                nx = clamp_norm(round_div(dx * NORM_ONE, root_d));
                ny = clamp_norm(round_div(dy * NORM_ONE, root_d));
                pen = rs - root_d;
            end
            sa = round_div(longint'(pen * ia), tot);
            sb = round_div(longint'(pen * ib), tot);
            apx += round_shift(nx * sa, ccr_pkg::NORM_FRAC);
            apy += round_shift(ny * sa, ccr_pkg::NORM_FRAC);
            bpx -= round_shift(nx * sb, ccr_pkg::NORM_FRAC);
            bpy -= round_shift(ny * sb, ccr_pkg::NORM_FRAC);
            wide = (avx - bvx) * nx + (avy - bvy) * ny;
            if (wide > 0) begin
                r.outcome = ccr_pkg::OUT_SEPARATE;
            end else begin
                e  = ea < eb ? ea : eb;
                vn = round_shift(-wide, ccr_pkg::NORM_FRAC);
                k  = round_shift(vn * longint'(256 + e), 8);
                ja = round_div(k * longint'(ia), tot);
                jb = round_div(k * longint'(ib), tot);
                avx += round_shift(ja * nx, ccr_pkg::NORM_FRAC);
                avy += round_shift(ja * ny, ccr_pkg::NORM_FRAC);
                bvx -= round_shift(jb * nx, ccr_pkg::NORM_FRAC);
                bvy -= round_shift(jb * ny, ccr_pkg::NORM_FRAC);
                r.outcome = ccr_pkg::OUT_IMPULSE;
            end
        end
        r.bod[0] = sat32(apx);
        r.bod[1] = sat32(apy);
        r.bod[2] = sat32(avx);
        r.bod[3] = sat32(avy);
        r.bod[4] = sat32(bpx);
        r.bod[5] = sat32(bpy);
        r.bod[6] = sat32(bvx);
        r.bod[7] = sat32(bvy);
        return r;
    endfunction

    string field_name[8] = '{"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
                             "new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};

    assign o_fail_count = fail_count;
    assign o_pending    = resolved_q.size();

    always @(posedge i_clk) begin
        t_resolved want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                resolved_q.push_back(resolve_pair(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (resolved_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = resolved_q.pop_front();
                    for (int f = 0; f < 8; f++) begin
                        if (i_m_tdata[f*32 +: 32] !== want.bod[f]) begin
                            $error("%s: expected %h, got %h", field_name[f],
                                   want.bod[f], i_m_tdata[f*32 +: 32]);
                            fail_count++;
                        end
                    end
                    if (i_m_tuser !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, i_m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> sim/circle_collision_resolve_tb.sv
// circle_collision_resolve_tb: directed and random body pairs with random
// gaps and output stalls; checking is done by ccr_checker.
// Depends on ccr_pkg, ccr_checker and circle_collision_resolve.
`timescale 1ns / 1ps

module circle_collision_resolve_tb;

    localparam int N_RANDOM   = 1650;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 150;      // idle wait after the last expected result, to catch extra ones

    typedef struct {
        logic [31:0] px, py, vx, vy;
        logic [30:0] radius;
        logic [23:0] inv_mass;
        logic [8:0]  rest;
    } t_body;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [383:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [255:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    int           fail_count;
    int           pending;
    int           cycles = 0;
    logic         stim_done;

    circle_collision_resolve DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    ccr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap drawn per request, 0..19; stretches of back-to-back traffic between
    function automatic int draw_gap(ref int run_left, ref bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(1, 60);
            calm = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [191:0] pack_body(t_body b);
        return {b.rest, b.inv_mass, b.radius, b.vy, b.vx, b.py, b.px};
    endfunction

    task automatic send_pair(t_body a, t_body b, int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pack_body(b), pack_body(a)};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic t_body rand_body();
        t_body b;
        b.px = $urandom; b.py = $urandom; b.vx = $urandom; b.vy = $urandom;
        b.radius = 31'($urandom); b.inv_mass = 24'($urandom); b.rest = 9'($urandom);
        return b;
    endfunction

    function automatic t_body mk(int px, int py, int vx, int vy, int r, int im, int e);
        t_body b;
        b.px = px; b.py = py; b.vx = vx; b.vy = vy;
        b.radius = 31'(r); b.inv_mass = 24'(im); b.rest = 9'(e);
        return b;
    endfunction

    // pair built to be near contact: each coordinate of A lies within the radius sum of B's, random content
    task automatic make_contact(output t_body a, output t_body b);
        int          rsum;
        int unsigned sel;
        a = rand_body();
        b = rand_body();
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            a.radius = 31'($urandom_range(1, 1 << 22));
            b.radius = 31'($urandom_range(0, 1 << 22));
        end else if (sel < 9) begin
            a.radius = 31'($urandom_range(0, 255));
            b.radius = 31'($urandom_range(0, 255));
        end
        rsum = (a.radius + b.radius > 32'h3fffffff) ? 32'h3fffffff : a.radius + b.radius;
        a.px = b.px + $signed($urandom_range(0, 2 * rsum)) - rsum;
        a.py = b.py + $signed($urandom_range(0, 2 * rsum)) - rsum;
        if ($urandom_range(0, 9) == 0) begin
            a.px = b.px + $signed($urandom_range(0, 8)) - 4;
            a.py = b.py;
        end
        if ($urandom_range(0, 1) == 0) begin
            a.vx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            a.vy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            b.vx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            b.vy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        case ($urandom_range(0, 15))
            0, 1:    a.inv_mass = '0;
            2, 3:    b.inv_mass = '0;
            4:       begin a.inv_mass = '0; b.inv_mass = '0; end
            default: ;
        endcase
    endtask

    // sender
    initial begin
        int    run_left;
        bit    calm;
        t_body a, b;
        t_body d_a[$], d_b[$];
        run_left   = 0;
        calm       = 0;
        stim_done  = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_rst_n    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // far apart: no contact
        d_a.push_back(mk(0, 0, 1, 1, 65536, 65536, 128));
        d_b.push_back(mk(32'h00100000, 0, 0, 0, 65536, 65536, 128));
        // touching exactly at the radius sum
        d_a.push_back(mk(131072, 0, -65536, 0, 65536, 65536, 256));
        d_b.push_back(mk(0, 0, 65536, 0, 65536, 65536, 256));
        // coincident centers
        d_a.push_back(mk(500, 500, 0, 3, 65536, 65536, 0));
        d_b.push_back(mk(500, 500, 7, 0, 65536, 32768, 511));
        // near-coincident, one raw unit apart
        d_a.push_back(mk(1, 0, 0, 0, 100, 1, 9));
        d_b.push_back(mk(0, 0, 0, 0, 100, 2, 9));
        // both immovable
        d_a.push_back(mk(0, 0, 65536, 0, 65536, 0, 256));
        d_b.push_back(mk(1000, 0, -65536, 0, 65536, 0, 256));
        // A immovable, B moves
        d_a.push_back(mk(0, 0, 0, 0, 65536, 0, 256));
        d_b.push_back(mk(30000, 40000, -65536, -65536, 65536, 65536, 256));
        // separating
        d_a.push_back(mk(50000, 0, 65536, 0, 65536, 65536, 256));
        d_b.push_back(mk(0, 0, -65536, 0, 65536, 65536, 256));
        // head-on, zero restitution
        d_a.push_back(mk(0, 50000, 0, -65536, 65536, 65536, 0));
        d_b.push_back(mk(0, 0, 0, 65536, 65536, 65536, 300));
        // top of the position range: pushes saturate high
        d_a.push_back(mk(32'h7fffffff, 32'h7fffffff, 0, 0, 31'h7fffffff, 1, 511));
        d_b.push_back(mk(32'h7ff00000, 32'h7ff00000, 0, 0, 31'h7fffffff, 1, 511));
        // bottom of the range
        d_a.push_back(mk(32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff, 24'hffffff, 511));
        d_b.push_back(mk(32'h80100000, 32'h80100000, 0, 0, 31'h7fffffff, 24'hffffff, 511));
        // extreme velocities approaching: impulse saturates
        d_a.push_back(mk(10, 10, 32'h80000000, 32'h80000000, 31'h7fffffff, 24'hffffff, 9'h1ff));
        d_b.push_back(mk(0, 0, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 24'hffffff, 9'h1ff));
        // all ones in the props, diagonal negative offset
        d_a.push_back(mk(-3000000, -4000000, 0, 0, 5000000, 24'hffffff, 9'h1ff));
        d_b.push_back(mk(0, 0, 0, 0, 31'h7fffffff, 24'hffffff, 9'h1ff));
        // all zero: coincident and immovable
        d_a.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        d_b.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        // zero radii, different centers
        d_a.push_back(mk(1, 0, 0, 0, 0, 5, 0));
        d_b.push_back(mk(0, 0, 0, 0, 0, 5, 0));
        // widest spread: opposite corners of the range
        d_a.push_back(mk(32'h7fffffff, 32'h7fffffff, 0, 0, 31'h7fffffff, 3, 0));
        d_b.push_back(mk(32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff, 3, 0));
        foreach (d_a[i])
            send_pair(d_a[i], d_b[i], draw_gap(run_left, calm));

        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                a = rand_body();
                b = rand_body();
            end else begin
                make_contact(a, b);
            end
            send_pair(a, b, draw_gap(run_left, calm));
        end
        i_s_tvalid <= 1'b0;
        stim_done  <= 1'b1;
    end

    // receiver: random holds on the result channel
    initial begin
        int run_left;
        bit calm;
        int w;
        run_left   = 0;
        calm       = 0;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            w = draw_gap(run_left, calm);
            if (w > 0) begin
                i_m_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // verdict
    initial begin
        @(posedge i_clk);
        wait (stim_done === 1'b1);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

>>> sim.f
hdl/ccr_pkg.sv
hdl/circle_collision_resolve.sv
sim/ccr_checker.sv
sim/circle_collision_resolve_tb.sv
